// ===== hw/rtl/wsm_pkg.sv =====
`default_nettype none

package wsm_pkg;

    localparam int PERIOD_W    = 16;
    localparam int SCALE_W     = 32;
    localparam int FRAC_W      = 16;
    localparam int SPEED_W     = 16;
    localparam int PULSE_W     = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_PERIOD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_PERIOD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBUG_PERIOD  = 3'd4;

    localparam logic [PERIOD_W-1:0] RST_NORMAL_PERIOD = 16'd1000;
    localparam logic [PERIOD_W-1:0] RST_LOW_PERIOD    = 16'd2000;
    localparam logic [SCALE_W-1:0]  RST_SPEED_SCALE   = 32'd0;
    localparam logic [PERIOD_W-1:0] RST_LED_PERIOD    = 16'd100;
    localparam logic [PERIOD_W-1:0] RST_DEBUG_PERIOD  = 16'd5000;

    typedef struct packed {
        logic [PERIOD_W-1:0] normal_period;
        logic [PERIOD_W-1:0] low_period;
        logic [PERIOD_W-1:0] led_period;
        logic [PERIOD_W-1:0] debug_period;
    } t_cfg;

    typedef struct packed {
        logic win_close;
        logic led_level;
        logic debug_due;
    } t_tick_res;

endpackage

`default_nettype wire

// ===== hw/rtl/wsm_tick.sv =====
`default_nettype none

module wsm_tick #(
    parameter int PULSE_SUM_WIDTH = 24,
    parameter int TIMER_WIDTH     = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_tick,
    input  wire logic [wsm_pkg::PULSE_W-1:0]  i_pulses,
    input  wire logic                         i_low,
    input  wire wsm_pkg::t_cfg                i_cfg,
    output logic                              o_valid,
    output wsm_pkg::t_tick_res                o_res,
    output logic [PULSE_SUM_WIDTH-1:0]        o_sum,
    output logic [TIMER_WIDTH-1:0]            o_elapsed
);

    localparam int PS = PULSE_SUM_WIDTH;
    localparam int TW = TIMER_WIDTH;
    localparam int CW = (TW > wsm_pkg::PERIOD_W) ? TW : wsm_pkg::PERIOD_W;

    logic [PS-1:0] r_sum;
    logic [TW-1:0] r_win;
    logic [TW-1:0] r_led_el;
    logic [TW-1:0] r_dbg_el;
    logic          r_led;
    logic          r_valid;
    wsm_pkg::t_tick_res r_res;
    logic [PS-1:0] r_sum_cap;
    logic [TW-1:0] r_el_cap;

    logic [PS:0]   sum_ext;
    logic [PS-1:0] n_sum;
    logic [TW-1:0] n_win;
    logic [TW-1:0] n_led_el;
    logic [TW-1:0] n_dbg_el;
    logic [wsm_pkg::PERIOD_W-1:0] period;
    logic          win_hit;
    logic          led_hit;
    logic          dbg_hit;

    always_comb begin
        sum_ext  = (PS+1)'(r_sum) + (PS+1)'(i_pulses);
        n_sum    = sum_ext[PS] ? {PS{1'b1}} : sum_ext[PS-1:0];
        n_win    = (&r_win)    ? r_win    : r_win + 1'b1;
        n_led_el = (&r_led_el) ? r_led_el : r_led_el + 1'b1;
        n_dbg_el = (&r_dbg_el) ? r_dbg_el : r_dbg_el + 1'b1;
        period   = i_low ? i_cfg.low_period : i_cfg.normal_period;
        win_hit  = CW'(n_win)    >= CW'(period);
        led_hit  = CW'(n_led_el) >= CW'(i_cfg.led_period);
        dbg_hit  = CW'(n_dbg_el) >= CW'(i_cfg.debug_period);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_win    <= '0;
            r_led_el <= '0;
            r_dbg_el <= '0;
            r_led    <= 1'b1;
            r_valid  <= 1'b0;
            r_res    <= '0;
        end else begin
            r_valid <= i_tick;
            if (i_tick) begin
                r_sum_cap <= n_sum;
                r_el_cap  <= n_win;
                r_sum     <= win_hit ? '0 : n_sum;
                r_win     <= win_hit ? '0 : n_win;
                r_dbg_el  <= dbg_hit ? '0 : n_dbg_el;
                // led timer keeps running under low supply, LED forced off
                if (i_low) begin
                    r_led    <= 1'b1;
                    r_led_el <= n_led_el;
                    r_res.led_level <= 1'b1;
                end else if (led_hit) begin
                    r_led    <= ~r_led;
                    r_led_el <= '0;
                    r_res.led_level <= ~r_led;
                end else begin
                    r_led_el <= n_led_el;
                    r_res.led_level <= r_led;
                end
                r_res.win_close <= win_hit;
                r_res.debug_due <= dbg_hit;
            end
        end
    end

    assign o_valid   = r_valid;
    assign o_res     = r_res;
    assign o_sum     = r_sum_cap;
    assign o_elapsed = r_el_cap;

endmodule

`default_nettype wire

// ===== hw/rtl/wsm_div.sv =====
`default_nettype none

module wsm_div #(
    parameter int PULSE_SUM_WIDTH = 24,
    parameter int TIMER_WIDTH     = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [PULSE_SUM_WIDTH-1:0]   i_sum,
    input  wire logic [TIMER_WIDTH-1:0]       i_elapsed,
    input  wire logic [wsm_pkg::SCALE_W-1:0]  i_scale,
    output logic                              o_done,
    output logic [wsm_pkg::SPEED_W-1:0]       o_quot
);

    localparam int PS   = PULSE_SUM_WIDTH;
    localparam int TW   = TIMER_WIDTH;
    localparam int SW   = wsm_pkg::SCALE_W;
    localparam int FW   = wsm_pkg::FRAC_W;
    localparam int QW   = wsm_pkg::SPEED_W;
    localparam int PW   = PS + SW;
    localparam int CW   = (PS > TW) ? PS : TW;
    localparam int CNTW = $clog2(PS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_CHK,
        S_DIV
    } t_state;

    t_state          r_state;
    logic [CNTW-1:0] r_cnt;
    logic [SW-1:0]   r_mcand;
    logic [PW-1:0]   r_prod;
    logic [TW-1:0]   r_den;
    logic [TW-1:0]   r_rem;
    logic [FW-1:0]   r_low;
    logic [QW-1:0]   r_quot;
    logic            r_done;

    logic [SW:0]     add;
    logic [PS-1:0]   hi;
    logic            ovf;
    logic [TW:0]     trial;
    logic [TW:0]     diff;
    logic            ge;

    always_comb begin
        add   = {1'b0, r_prod[PW-1:PS]} + (r_prod[0] ? {1'b0, r_mcand} : '0);
        // product >> 32 is the dividend's high half, checked against the divisor for overflow
        hi    = r_prod[PW-1:SW];
        ovf   = CW'(hi) >= CW'(r_den);
        trial = {r_rem, r_low[FW-1]};
        diff  = trial - {1'b0, r_den};
        ge    = trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_mcand <= i_scale;
                        r_prod  <= {{SW{1'b0}}, i_sum};
                        r_den   <= i_elapsed;
                        r_cnt   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod <= {add, r_prod[PS-1:1]};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CNTW'(PS - 1)) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (ovf) begin
                        r_quot  <= '1;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_rem   <= TW'(hi);
                        r_low   <= r_prod[SW-1:SW-FW];
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= ge ? diff[TW-1:0] : trial[TW-1:0];
                    r_quot <= {r_quot[QW-2:0], ge};
                    r_low  <= {r_low[FW-2:0], 1'b0};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CNTW'(QW - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

// ===== hw/rtl/wheel_speed_meter_with_heartbeat_top.sv =====
// Wheel speed meter with heartbeat LED and debug timer.
// Slave stream: one beat per millisecond tick; tdata carries the wheel pulse
// count, tuser the low-supply flag. Master stream: exactly one beat per
// input beat; tuser is speed_valid, tdata holds the speed, led_level and
// debug_due. Configuration registers are written on the cfg channel, which
// is always ready; write them only while no tick is in flight.
// A tick that does not close a window passes from acceptance through the
// tick registers and the S_TICK state to S_OUT, which loads the output
// register. A tick that closes a window also runs the serial multiply (one
// pulse-sum bit per cycle), a check step and the restoring divide before
// S_OUT; when the speed saturates, the check skips the divide.
// The block takes one tick at a time; the next tick is taken once the previous
// result has moved into the output register, even if that beat is still
// waiting. A stalled master holds the output beat and the slave side then
// stays not ready after the following tick is computed.
// Reset (synchronous, active low) clears all timers and the pulse sum, puts
// the LED off and loads the default periods and a zero speed scale.
`default_nettype none

module wheel_speed_meter_with_heartbeat_top #(
    parameter int PULSE_SUM_WIDTH = 24,
    parameter int TIMER_WIDTH     = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [7:0] pulse_count
    input  wire logic [wsm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [0] low_supply
    input  wire logic                              s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [15:0] speed, [16] led_level, [17] debug_due
    output logic [wsm_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    // [0] speed_valid
    output logic                                   m_axis_tuser,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [wsm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [wsm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int QW  = wsm_pkg::SPEED_W;
    localparam int PAD = wsm_pkg::OUT_TDATA_W - QW - 2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK,
        S_DIV,
        S_OUT
    } t_state;

    wsm_pkg::t_cfg              r_cfg;
    logic [wsm_pkg::SCALE_W-1:0] r_scale;

    t_state                     r_state;
    wsm_pkg::t_tick_res         r_res;
    logic [QW-1:0]              r_speed;
    logic                       r_m_valid;
    logic [wsm_pkg::OUT_TDATA_W-1:0] r_m_data;
    logic                       r_m_user;

    logic                       in_beat;
    logic                       tick_valid;
    wsm_pkg::t_tick_res         tick_res;
    logic [PULSE_SUM_WIDTH-1:0] tick_sum;
    logic [TIMER_WIDTH-1:0]     tick_el;
    logic                       div_start;
    logic                       div_done;
    logic [QW-1:0]              div_quot;
    logic                       out_free;
    logic                       out_load;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign div_start     = tick_valid && tick_res.win_close;
    assign out_free      = !r_m_valid || m_axis_tready;
    assign out_load      = (r_state == S_OUT) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.normal_period <= wsm_pkg::RST_NORMAL_PERIOD;
            r_cfg.low_period    <= wsm_pkg::RST_LOW_PERIOD;
            r_cfg.led_period    <= wsm_pkg::RST_LED_PERIOD;
            r_cfg.debug_period  <= wsm_pkg::RST_DEBUG_PERIOD;
            r_scale             <= wsm_pkg::RST_SPEED_SCALE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                wsm_pkg::CFG_NORMAL_PERIOD: begin
                    r_cfg.normal_period <= i_cfg_data[wsm_pkg::PERIOD_W-1:0];
                end
                wsm_pkg::CFG_LOW_PERIOD: begin
                    r_cfg.low_period <= i_cfg_data[wsm_pkg::PERIOD_W-1:0];
                end
                wsm_pkg::CFG_SPEED_SCALE: begin
                    r_scale <= i_cfg_data[wsm_pkg::SCALE_W-1:0];
                end
                wsm_pkg::CFG_LED_PERIOD: begin
                    r_cfg.led_period <= i_cfg_data[wsm_pkg::PERIOD_W-1:0];
                end
                wsm_pkg::CFG_DEBUG_PERIOD: begin
                    r_cfg.debug_period <= i_cfg_data[wsm_pkg::PERIOD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    wsm_tick #(
        .PULSE_SUM_WIDTH (PULSE_SUM_WIDTH),
        .TIMER_WIDTH     (TIMER_WIDTH)
    ) u_tick (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tick    (in_beat),
        .i_pulses  (s_axis_tdata[wsm_pkg::PULSE_W-1:0]),
        .i_low     (s_axis_tuser),
        .i_cfg     (r_cfg),
        .o_valid   (tick_valid),
        .o_res     (tick_res),
        .o_sum     (tick_sum),
        .o_elapsed (tick_el)
    );

    wsm_div #(
        .PULSE_SUM_WIDTH (PULSE_SUM_WIDTH),
        .TIMER_WIDTH     (TIMER_WIDTH)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_sum     (tick_sum),
        .i_elapsed (tick_el),
        .i_scale   (r_scale),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
            r_res     <= '0;
        end else begin
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        r_state <= S_TICK;
                    end
                end
                S_TICK: begin
                    r_res   <= tick_res;
                    r_speed <= '0;
                    r_state <= tick_res.win_close ? S_DIV : S_OUT;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_speed <= div_quot;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_m_user  <= r_res.win_close;
                        r_m_data  <= {{PAD{1'b0}}, r_res.debug_due, r_res.led_level,
                                      r_speed};
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule

`default_nettype wire

// ===== sim/wsm_tick_checker.sv =====
`timescale 1ns / 100ps

module wsm_tick_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    input  logic                                i_s_tready,
    input  logic [wsm_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    input  logic                                i_s_tuser,
    input  logic                                i_m_tvalid,
    input  logic                                i_m_tready,
    input  logic [wsm_pkg::OUT_TDATA_W-1:0]     i_m_tdata,
    input  logic                                i_m_tuser,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [wsm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [wsm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_windows
);

    localparam int SUM_W = 24;
    localparam int TMR_W = 16;
    localparam int PW    = wsm_pkg::PERIOD_W;
    localparam int SPW   = wsm_pkg::SPEED_W;
    localparam int NW    = wsm_pkg::PULSE_W;

    typedef struct packed {
        logic           speed_valid;
        logic [SPW-1:0] speed;
        logic           led_level;
        logic           debug_due;
    } t_tick_out;

    t_tick_out expected_ticks[$];
    t_tick_out want;

    logic [SUM_W-1:0]              pulse_acc;
    logic [TMR_W-1:0]              win_ms;
    logic [TMR_W-1:0]              led_ms;
    logic [TMR_W-1:0]              dbg_ms;
    logic                          led_off;
    logic [PW-1:0]                 cfg_normal;
    logic [PW-1:0]                 cfg_low;
    logic [wsm_pkg::SCALE_W-1:0]   cfg_scale;
    logic [PW-1:0]                 cfg_led;
    logic [PW-1:0]                 cfg_dbg;
    int                            fails   = 0;
    int                            windows = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_windows    = 0;
    end

    function automatic logic [TMR_W-1:0] inc_sat(input logic [TMR_W-1:0] v);
        return (v == {TMR_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic t_tick_out advance_tick(input logic [NW-1:0] pulses,
                                               input logic low);
        logic [PW-1:0]       period;
        logic [SUM_W:0]      sum_wide;
        logic [55:0]         product;
        logic [55:0]         quot;
        t_tick_out           r;
        r = '0;
        win_ms = inc_sat(win_ms);
        led_ms = inc_sat(led_ms);
        dbg_ms = inc_sat(dbg_ms);
        sum_wide  = {1'b0, pulse_acc} + (SUM_W + 1)'(pulses);
        pulse_acc = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
        period = low ? cfg_low : cfg_normal;
        if (win_ms >= period) begin
            product = 56'(pulse_acc) * 56'(cfg_scale);
            quot    = product / 56'({win_ms, 16'h0000});
            r.speed       = (quot > 56'hFFFF) ? 16'hFFFF : quot[SPW-1:0];
            r.speed_valid = 1'b1;
            windows++;
            pulse_acc = '0;
            win_ms    = '0;
        end
        // LED held off on low supply, its timer keeps running
        if (low) begin
            led_off = 1'b1;
        end else if (led_ms >= cfg_led) begin
            led_off = ~led_off;
            led_ms  = '0;
        end
        if (dbg_ms >= cfg_dbg) begin
            r.debug_due = 1'b1;
            dbg_ms      = '0;
        end
        r.led_level = led_off;
        return r;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            fails++;
            $display("%0t: %s expected %0h actual %0h", $time, what, exp_v, act_v);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_ticks.delete();
            pulse_acc  = '0;
            win_ms     = '0;
            led_ms     = '0;
            dbg_ms     = '0;
            led_off    = 1'b1;
            cfg_normal = wsm_pkg::RST_NORMAL_PERIOD;
            cfg_low    = wsm_pkg::RST_LOW_PERIOD;
            cfg_scale  = wsm_pkg::RST_SPEED_SCALE;
            cfg_led    = wsm_pkg::RST_LED_PERIOD;
            cfg_dbg    = wsm_pkg::RST_DEBUG_PERIOD;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_ticks.size() == 0) begin
                    fails++;
                    $display("%0t: output beat expected none actual tdata %h tuser %b",
                             $time, i_m_tdata, i_m_tuser);
                end else begin
                    want = expected_ticks.pop_front();
                    check_field("speed_valid", 32'(want.speed_valid), 32'(i_m_tuser));
                    check_field("speed", 32'(want.speed), 32'(i_m_tdata[15:0]));
                    check_field("led_level", 32'(want.led_level), 32'(i_m_tdata[16]));
                    check_field("debug_due", 32'(want.debug_due), 32'(i_m_tdata[17]));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    wsm_pkg::CFG_NORMAL_PERIOD: cfg_normal = i_cfg_data[PW-1:0];
                    wsm_pkg::CFG_LOW_PERIOD:    cfg_low    = i_cfg_data[PW-1:0];
                    wsm_pkg::CFG_SPEED_SCALE:
                        cfg_scale = i_cfg_data[wsm_pkg::SCALE_W-1:0];
                    wsm_pkg::CFG_LED_PERIOD:    cfg_led    = i_cfg_data[PW-1:0];
                    wsm_pkg::CFG_DEBUG_PERIOD:  cfg_dbg    = i_cfg_data[PW-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                expected_ticks.push_back(advance_tick(i_s_tdata[NW-1:0], i_s_tuser));
        end
        o_pending    <= expected_ticks.size();
        o_fail_count <= fails;
        o_windows    <= windows;
    end

endmodule

// ===== sim/wheel_speed_meter_with_heartbeat_top_tb.sv =====
`timescale 1ns / 100ps

module wheel_speed_meter_with_heartbeat_top_tb;

    localparam int PHASE_TICKS = 211;
    localparam int HOLD_CYCLES = 500;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int PW          = wsm_pkg::PERIOD_W;
    localparam int DW          = wsm_pkg::CFG_DATA_W;
    localparam int NW          = wsm_pkg::PULSE_W;
    localparam logic [wsm_pkg::CFG_IDX_W-1:0] UNMAPPED_REG = 3'd7;

    logic                              i_clk         = 1'b0;
    logic                              i_rst_n       = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [wsm_pkg::IN_TDATA_W-1:0]    s_axis_tdata  = '0;
    logic                              s_axis_tuser  = 1'b0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [wsm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;
    logic                              m_axis_tuser;
    logic                              i_cfg_valid   = 1'b0;
    logic                              o_cfg_ready;
    logic [wsm_pkg::CFG_IDX_W-1:0]     i_cfg_index   = '0;
    logic [DW-1:0]                     i_cfg_data    = '0;

    int fail_count;
    int pending;
    int windows;
    int cycle_count  = 0;
    int ticks_sent   = 0;
    int settings_run = 0;
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int hold_ticket  = 0;
    int hold_seen    = 0;
    int hold_left    = 0;

    wheel_speed_meter_with_heartbeat_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    wsm_tick_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_windows    (windows)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("wheel_speed_meter_with_heartbeat_top: mismatch");
            $finish;
        end
    end

    // result side: random stalls plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_seen != hold_ticket) begin
            hold_seen     <= hold_ticket;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    task automatic send_tick(input logic [NW-1:0] pulses, input logic low);
        if (snd_idle_pct != 0 && $urandom_range(0, 99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pulses;
        s_axis_tuser  <= low;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        ticks_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [wsm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [DW-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [PW-1:0]               normal_p,
                                 input logic [PW-1:0]               low_p,
                                 input logic [wsm_pkg::SCALE_W-1:0] scale,
                                 input logic [PW-1:0]               led_p,
                                 input logic [PW-1:0]               dbg_p);
        wait_drained();
        write_reg(wsm_pkg::CFG_NORMAL_PERIOD, DW'(normal_p));
        write_reg(wsm_pkg::CFG_LOW_PERIOD, DW'(low_p));
        write_reg(wsm_pkg::CFG_SPEED_SCALE, scale);
        write_reg(wsm_pkg::CFG_LED_PERIOD, DW'(led_p));
        write_reg(wsm_pkg::CFG_DEBUG_PERIOD, DW'(dbg_p));
        i_cfg_valid <= 1'b0;
        settings_run++;
    endtask

    function automatic logic [PW-1:0] pick_period();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 16'd1;
            2:       return 16'hFFFF;
            3, 4, 5: return PW'($urandom_range(1, 6));
            6, 7:    return PW'($urandom_range(2, 40));
            8:       return PW'($urandom_range(41, 300));
            default: return PW'($urandom);
        endcase
    endfunction

    function automatic logic [wsm_pkg::SCALE_W-1:0] pick_scale();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return '1;
            2:       return $urandom;
            3, 4:    return $urandom >> $urandom_range(4, 28);
            default: return $urandom_range(32'd20000000, 32'd80000000);
        endcase
    endfunction

    initial begin
        int                  sent;
        int                  run_len;
        int                  style;
        logic                run_low;
        logic                low;
        logic [NW-1:0]       pulses;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values of the registers
        send_tick(8'hFF, 1'b0);

        apply_setting(16'd3, 16'd5, 32'hFFFF_FFFF, 16'd2, 16'd4);
        write_reg(UNMAPPED_REG, 32'h0000_0001);
        i_cfg_valid <= 1'b0;
        send_tick(8'h00, 1'b0);
        send_tick(8'hFF, 1'b0);
        send_tick(8'hFF, 1'b0);
        send_tick(8'h01, 1'b0);
        send_tick(8'h00, 1'b0);
        send_tick(8'h80, 1'b0);
        send_tick(8'h55, 1'b1);
        send_tick(8'hAA, 1'b1);
        send_tick(8'hFF, 1'b1);
        send_tick(8'h00, 1'b1);
        send_tick(8'h01, 1'b1);
        send_tick(8'h03, 1'b0);
        send_tick(8'h00, 1'b0);
        send_tick(8'h00, 1'b0);

        // zero periods fire every tick
        apply_setting(16'd0, 16'd0, 32'd0, 16'd0, 16'd0);
        send_tick(8'hFF, 1'b0);
        send_tick(8'h00, 1'b1);
        send_tick(8'h07, 1'b0);

        // unit scale, exact quotient
        apply_setting(16'd2, 16'd1, 32'h0001_0000, 16'd3, 16'd2);
        send_tick(8'd200, 1'b0);
        send_tick(8'd100, 1'b0);

        for (int ph = 0; ph < 9; ph++) begin
            case (ph / 3)
                0:       snd_idle_pct = 27;
                1:       snd_idle_pct = 83;
                default: snd_idle_pct = 0;
            endcase
            if (ph == 0)
                apply_setting(16'd1, 16'd1, 32'hFFFF_FFFF, 16'd1, 16'd1);
            else if (ph == 4)
                apply_setting(16'hFFFF, 16'd2, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
            else
                apply_setting(pick_period(), pick_period(), pick_scale(), pick_period(),
                              pick_period());
            case (ph / 3)
                0:       rcv_idle_pct <= 83;
                1:       rcv_idle_pct <= 27;
                default: rcv_idle_pct <= 0;
            endcase
            sent = 0;
            while (sent < PHASE_TICKS) begin
                run_len = $urandom_range(1, 40);
                run_low = ($urandom_range(0, 99) < 30);
                style   = $urandom_range(0, 4);
                for (int k = 0; k < run_len && sent < PHASE_TICKS; k++) begin
                    case (style)
                        0:       pulses = '0;
                        1:       pulses = '1;
                        2:       pulses = NW'($urandom_range(0, 3));
                        3:       pulses = NW'($urandom);
                        default: pulses = k[0] ? 8'h55 : 8'hAA;
                    endcase
                    low = ($urandom_range(0, 19) == 0) ? !run_low : run_low;
                    if (ph == 6 && sent == 60)
                        hold_ticket <= hold_ticket + 1;
                    if (ph == 4 && sent == 100)
                        wait_drained();
                    send_tick(pulses, low);
                    sent++;
                end
            end
        end

        wait_drained();
        repeat (60) @(posedge i_clk);
        $display("%0d ticks over %0d register settings, %0d speed windows closed",
                 ticks_sent, settings_run, windows);
        $display("idle sender/receiver: 27/83, 83/27, 0/0; one %0d-cycle result hold-off",
                 HOLD_CYCLES);
        if (fail_count == 0 && pending == 0)
            $display("wheel_speed_meter_with_heartbeat_top: match");
        else
            $display("wheel_speed_meter_with_heartbeat_top: mismatch");
        $finish;
    end

endmodule
